/* src/tmcr_pkg.sv */
`default_nettype none
package tmcr_pkg;

  localparam int unsigned GLYPH_ROWS = 32;
  localparam int unsigned NUM_SETS   = 2;
  localparam int unsigned NUM_CHARS  = 256;
  localparam int unsigned GLYPH_DEPTH = NUM_SETS * NUM_CHARS * GLYPH_ROWS;
  localparam int unsigned GLYPH_AW    = $clog2(GLYPH_DEPTH);
  localparam int unsigned SET_STRIDE  = NUM_CHARS * GLYPH_ROWS;

  localparam int unsigned APB_AW = 5;

  typedef enum logic [1:0] {
    CmdDraw  = 2'd0,
    CmdWrite = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    RegBlinkEnable  = 3'd0,
    RegCursorEnable = 3'd1,
    RegCursorLoc    = 3'd2,
    RegCursorStart  = 3'd3,
    RegCursorEnd    = 3'd4
  } reg_idx_e;

  // decoded draw request waiting for its glyph byte
  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic       row_en;
    logic       cursor;
  } draw_ctl_t;

  function automatic logic [GLYPH_AW-1:0] glyph_addr(input logic       set,
                                                     input logic [7:0] chr,
                                                     input logic [4:0] line);
    logic [GLYPH_AW:0] sum;
    sum = (GLYPH_AW+1)'(set) * (GLYPH_AW+1)'(SET_STRIDE)
        + (GLYPH_AW+1)'(chr) * (GLYPH_AW+1)'(GLYPH_ROWS)
        + (GLYPH_AW+1)'(line);
    return sum[GLYPH_AW-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/tmcr_in_if.sv */
`default_nettype none
interface tmcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  char_code;
  logic [7:0]  attribute;
  logic [4:0]  scan_line;
  logic [15:0] cell_index;
  logic        font_set;
  logic [7:0]  glyph_byte;

  modport source (output valid, cmd, char_code, attribute, scan_line, cell_index,
                  font_set, glyph_byte, input ready);
  modport sink (input valid, cmd, char_code, attribute, scan_line, cell_index,
                font_set, glyph_byte, output ready);
endinterface
`default_nettype wire

/* src/tmcr_out_if.sv */
`default_nettype none
interface tmcr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_0;
  logic [3:0] pixel_1;
  logic [3:0] pixel_2;
  logic [3:0] pixel_3;
  logic [3:0] pixel_4;
  logic [3:0] pixel_5;
  logic [3:0] pixel_6;
  logic [3:0] pixel_7;

  modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, input ready);
  modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                pixel_6, pixel_7, output ready);
endinterface
`default_nettype wire

/* src/text_mode_cell_renderer_top.sv */
// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    cmd, char_code, attribute, scan_line, cell_index,
//                               font_set, glyph_byte
// rsp_o     out  valid/ready    pixel_0 .. pixel_7 (draw requests only)
// apb       in   psel/penable   blink, cursor enable/location/start/end lines
//
// One request per cycle while ready is high. A draw reads the glyph RAM at acceptance;
// the registered glyph byte and the stage-1 control form the pixels, which are
// registered into the output register. Writes and ticks finish at acceptance.
// Reset initialises control and configuration; the glyph RAM is not cleared.
// A stalled output holds the glyph stage; ready drops only when both are full.
`default_nettype none
module text_mode_cell_renderer_top
  import tmcr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tmcr_in_if.sink                req_i,
  tmcr_out_if.source             rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic        blink_q;
  logic        cur_en_q;
  logic [15:0] cur_loc_q;
  logic [4:0]  cur_start_q;
  logic [4:0]  cur_end_q;
  logic [4:0]  frame_q;

  logic      s1_valid_q;
  draw_ctl_t s1_ctl_q, s1_ctl_d;
  logic      out_valid_q;
  logic [3:0] pix_q [8];
  logic [3:0] pix_d [8];

  logic       apb_wr;
  logic [2:0] reg_idx;
  logic       in_acc, s1_adv, is_draw, is_write, line_ok;
  logic [7:0] glyph_rd, row;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign apb_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q     <= 1'b1;
      cur_en_q    <= 1'b0;
      cur_loc_q   <= '0;
      cur_start_q <= '0;
      cur_end_q   <= 5'h1f;
    end else if (apb_wr) begin
      case (reg_idx)
        RegBlinkEnable:  blink_q     <= pwdata[0];
        RegCursorEnable: cur_en_q    <= pwdata[0];
        RegCursorLoc:    cur_loc_q   <= pwdata[15:0];
        RegCursorStart:  cur_start_q <= pwdata[4:0];
        RegCursorEnd:    cur_end_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegBlinkEnable:  prdata = {31'b0, blink_q};
      RegCursorEnable: prdata = {31'b0, cur_en_q};
      RegCursorLoc:    prdata = {16'b0, cur_loc_q};
      RegCursorStart:  prdata = {27'b0, cur_start_q};
      RegCursorEnd:    prdata = {27'b0, cur_end_q};
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign s1_adv      = s1_valid_q & (~out_valid_q | rsp_o.ready);
  assign req_i.ready = ~s1_valid_q | s1_adv;
  assign in_acc      = req_i.valid & req_i.ready;
  assign is_draw     = (req_i.cmd == CmdDraw);
  assign is_write    = (req_i.cmd == CmdWrite);
  assign line_ok     = {1'b0, req_i.scan_line} < 6'(GLYPH_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (in_acc && req_i.cmd == CmdTick) begin
      frame_q <= frame_q + 5'd1;
    end
  end

  tmcr_glyph_ram u_ram (
    .clk_i   (clk_i),
    .en_i    (in_acc & ((is_write & line_ok) | is_draw)),
    .we_i    (is_write),
    .addr_i  (glyph_addr(is_write ? req_i.font_set : req_i.attribute[3],
                         req_i.char_code, req_i.scan_line)),
    .wdata_i (req_i.glyph_byte),
    .rdata_o (glyph_rd)
  );

  always_comb begin
    s1_ctl_d.fg     = req_i.attribute[3:0];
    s1_ctl_d.bg     = blink_q ? {1'b0, req_i.attribute[6:4]} : req_i.attribute[7:4];
    // blinking glyph hidden in the second half of the blink period
    s1_ctl_d.row_en = line_ok & ~(blink_q & req_i.attribute[7] & frame_q[4]);
    s1_ctl_d.cursor = cur_en_q & frame_q[3] & (req_i.cell_index == cur_loc_q)
                    & (req_i.scan_line >= cur_start_q) & (req_i.scan_line <= cur_end_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= in_acc & is_draw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_draw) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  assign row = s1_ctl_q.row_en ? glyph_rd : 8'h00;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pix_d[k] = (s1_ctl_q.cursor | row[7-k]) ? s1_ctl_q.fg : s1_ctl_q.bg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pix_q <= pix_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.pixel_0 = pix_q[0];
  assign rsp_o.pixel_1 = pix_q[1];
  assign rsp_o.pixel_2 = pix_q[2];
  assign rsp_o.pixel_3 = pix_q[3];
  assign rsp_o.pixel_4 = pix_q[4];
  assign rsp_o.pixel_5 = pix_q[5];
  assign rsp_o.pixel_6 = pix_q[6];
  assign rsp_o.pixel_7 = pix_q[7];

endmodule
`default_nettype wire

/* src/tmcr_glyph_ram.sv */
`default_nettype none
module tmcr_glyph_ram
  import tmcr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic                we_i,
  input  wire logic [GLYPH_AW-1:0] addr_i,
  input  wire logic [7:0]          wdata_i,
  output logic      [7:0]          rdata_o
);

  logic [7:0] mem [GLYPH_DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule
`default_nettype wire
